// ===== hdl/sldc_pkg.sv =====
// Shared types and constants for the stereo log-domain compressor.
package sldc_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int NORM_BITS       = 24;
  localparam int MAG_W           = NORM_BITS + 1;
  localparam int MUL_W           = 33;
  localparam int PROD_W          = 2 * MUL_W;
  localparam int ACC_W           = PROD_W + 1;
  localparam int CFG_W           = 17;
  localparam int CFG_IDX_W       = 3;

  localparam logic signed [15:0] THR_RESET   = 16'sd256;
  localparam logic [14:0]        IR_RESET    = 15'd16384;
  localparam logic [16:0]        ATT_RESET   = 17'd32768;
  localparam logic [16:0]        REL_RESET   = 17'd32768;
  localparam logic [15:0]        MK_RESET    = 16'd4096;
  localparam logic [16:0]        ALPHA_RESET = 17'd62915;
  localparam logic [16:0]        W_RESET     = 17'd655;

  localparam logic [16:0]        ONE_Q16     = 17'd65536;
  localparam logic [14:0]        ONE_Q14     = 15'd16384;
  localparam logic [15:0]        DB_PER_LOG2 = 16'd49316;
  localparam logic [13:0]        LOG2_PER_DB = 14'd10885;
  localparam logic [12:0]        POLY_C3     = 13'd5155;
  localparam logic [13:0]        POLY_C2     = 14'd14822;
  localparam logic [15:0]        POLY_C1     = 16'd45559;
  localparam logic signed [15:0] LEVEL_FLOOR = -16'sd32768;
  localparam logic signed [23:0] ENV_RESET   = 24'sd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_INV_RATIO = 3'd1,
    CFG_ATTACK    = 3'd2,
    CFG_RELEASE   = 3'd3,
    CFG_MAKEUP    = 3'd4,
    CFG_ALPHA     = 3'd5,
    CFG_IN_WEIGHT = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic signed [15:0] thr;
    logic [14:0]        ir;
    logic [16:0]        att;
    logic [16:0]        rel;
    logic [15:0]        mk;
    logic [16:0]        alpha;
    logic [16:0]        w;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_SQ, OP_MS_HI, OP_MS_LO, OP_S2_HI, OP_S2_LO, OP_MS_SUM,
    OP_NORM, OP_MANT, OP_LOG, OP_LVL_MUL, OP_LVL, OP_TGT_MUL, OP_TGT,
    OP_ENV_A, OP_ENV_B, OP_ENV_C, OP_E_MUL, OP_E, OP_H1, OP_H2, OP_H3,
    OP_MK, OP_OL, OP_OR, OP_OUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] cnt;
  } cmd_t;

endpackage

// ===== hdl/stereo_log_domain_compressor.sv =====
// Top level of the stereo-linked log-domain RMS compressor.
//
// Input channel in_valid/in_ready carries one left/right sample pair per beat.
// Output channel out_valid/out_ready carries the compressed pair, one beat per
// input beat, in order. The cfg_we/cfg_index/cfg_wdata port writes the seven
// setup registers (threshold, inverse ratio, attack, release, makeup, power
// alpha, power input weight), one per write; write them only while idle.
// One pair is worked at a time by a single shared 33x33 multiplier, sequenced
// step by step; the 16-step log2 squaring loop dominates. in_ready is high
// only between pairs.
// The result sits in an output register, so a new pair is accepted while an
// earlier one still waits; if the receiver stalls, the sequencer holds at its
// last step until the output register frees up.
// Reset (rst_n low, synchronous) restores the register defaults, clears the
// mean square, sets the envelope to 1 dB and drops out_valid.
module stereo_log_domain_compressor #(
  parameter int SAMPLE_BITS = sldc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_BITS-1:0]  in_left_sample,
  input  logic signed [SAMPLE_BITS-1:0]  in_right_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_BITS-1:0]  out_left_out,
  output logic signed [SAMPLE_BITS-1:0]  out_right_out,
  input  logic                           cfg_we,
  input  logic [sldc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sldc_pkg::CFG_W-1:0]     cfg_wdata
);
  import sldc_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  sldc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sldc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  sldc_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cfg             (cfg),
    .in_left_sample  (in_left_sample),
    .in_right_sample (in_right_sample),
    .out_left_out    (out_left_out),
    .out_right_out   (out_right_out)
  );

endmodule

// ===== hdl/sldc_cfg.sv =====
// Configuration register file with range capping.
module sldc_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [sldc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sldc_pkg::CFG_W-1:0]      cfg_wdata,
  output sldc_pkg::cfg_t                  cfg
);
  import sldc_pkg::*;

  logic signed [15:0] thr_r;
  logic [14:0]        ir_r;
  logic [16:0]        att_r, rel_r, alpha_r, w_r;
  logic [15:0]        mk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= THR_RESET;
      ir_r    <= IR_RESET;
      att_r   <= ATT_RESET;
      rel_r   <= REL_RESET;
      mk_r    <= MK_RESET;
      alpha_r <= ALPHA_RESET;
      w_r     <= W_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_THRESHOLD: thr_r   <= cfg_wdata[15:0];
        CFG_INV_RATIO: ir_r    <= cfg_wdata[14:0];
        CFG_ATTACK:    att_r   <= cfg_wdata;
        CFG_RELEASE:   rel_r   <= cfg_wdata;
        CFG_MAKEUP:    mk_r    <= cfg_wdata[15:0];
        CFG_ALPHA:     alpha_r <= cfg_wdata;
        CFG_IN_WEIGHT: w_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.thr   = thr_r;
    cfg.ir    = (ir_r > ONE_Q14) ? ONE_Q14 : ir_r;
    cfg.att   = (att_r > ONE_Q16) ? ONE_Q16 : att_r;
    cfg.rel   = (rel_r > ONE_Q16) ? ONE_Q16 : rel_r;
    cfg.mk    = mk_r;
    cfg.alpha = (alpha_r > ONE_Q16) ? ONE_Q16 : alpha_r;
    cfg.w     = (w_r > ONE_Q16) ? ONE_Q16 : w_r;
  end

endmodule

// ===== hdl/sldc_ctrl.sv =====
// Sequencer FSM and output handshake for the compressor.
module sldc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output sldc_pkg::cmd_t cmd
);
  import sldc_pkg::*;

  typedef enum logic [25:0] {
    ST_IDLE    = 26'h0000001,
    ST_SQ      = 26'h0000002,
    ST_MS_HI   = 26'h0000004,
    ST_MS_LO   = 26'h0000008,
    ST_S2_HI   = 26'h0000010,
    ST_S2_LO   = 26'h0000020,
    ST_MS_SUM  = 26'h0000040,
    ST_NORM    = 26'h0000080,
    ST_MANT    = 26'h0000100,
    ST_LOG     = 26'h0000200,
    ST_LVL_MUL = 26'h0000400,
    ST_LVL     = 26'h0000800,
    ST_TGT_MUL = 26'h0001000,
    ST_TGT     = 26'h0002000,
    ST_ENV_A   = 26'h0004000,
    ST_ENV_B   = 26'h0008000,
    ST_ENV_C   = 26'h0010000,
    ST_E_MUL   = 26'h0020000,
    ST_E       = 26'h0040000,
    ST_H1      = 26'h0080000,
    ST_H2      = 26'h0100000,
    ST_H3      = 26'h0200000,
    ST_MK      = 26'h0400000,
    ST_OL      = 26'h0800000,
    ST_OR      = 26'h1000000,
    ST_OUT     = 26'h2000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       load_out;

  assign load_out  = (state_r == ST_OUT) && (!out_valid_r || out_ready);
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd.cnt   = cnt_r;
    cmd.op    = OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_SQ;
        end
      end
      ST_SQ:      begin cmd.op = OP_SQ;    state_nxt = ST_MS_HI; end
      ST_MS_HI:   begin cmd.op = OP_MS_HI; state_nxt = ST_MS_LO; end
      ST_MS_LO:   begin cmd.op = OP_MS_LO; state_nxt = ST_S2_HI; end
      ST_S2_HI:   begin cmd.op = OP_S2_HI; state_nxt = ST_S2_LO; end
      ST_S2_LO:   begin cmd.op = OP_S2_LO; state_nxt = ST_MS_SUM; end
      ST_MS_SUM: begin
        cmd.op    = OP_MS_SUM;
        cnt_nxt   = 4'd0;
        state_nxt = ST_NORM;
      end
      ST_NORM: begin
        cmd.op = OP_NORM;
        if (cnt_r == 4'd5) begin
          cnt_nxt   = 4'd15;
          state_nxt = ST_MANT;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      ST_MANT:    begin cmd.op = OP_MANT; state_nxt = ST_LOG; end
      ST_LOG: begin
        cmd.op = OP_LOG;
        if (cnt_r == 4'd0) begin
          state_nxt = ST_LVL_MUL;
        end else begin
          cnt_nxt = cnt_r - 4'd1;
        end
      end
      ST_LVL_MUL: begin cmd.op = OP_LVL_MUL; state_nxt = ST_LVL; end
      ST_LVL:     begin cmd.op = OP_LVL;     state_nxt = ST_TGT_MUL; end
      ST_TGT_MUL: begin cmd.op = OP_TGT_MUL; state_nxt = ST_TGT; end
      ST_TGT:     begin cmd.op = OP_TGT;     state_nxt = ST_ENV_A; end
      ST_ENV_A:   begin cmd.op = OP_ENV_A;   state_nxt = ST_ENV_B; end
      ST_ENV_B:   begin cmd.op = OP_ENV_B;   state_nxt = ST_ENV_C; end
      ST_ENV_C:   begin cmd.op = OP_ENV_C;   state_nxt = ST_E_MUL; end
      ST_E_MUL:   begin cmd.op = OP_E_MUL;   state_nxt = ST_E; end
      ST_E:       begin cmd.op = OP_E;       state_nxt = ST_H1; end
      ST_H1:      begin cmd.op = OP_H1;      state_nxt = ST_H2; end
      ST_H2:      begin cmd.op = OP_H2;      state_nxt = ST_H3; end
      ST_H3:      begin cmd.op = OP_H3;      state_nxt = ST_MK; end
      ST_MK:      begin cmd.op = OP_MK;      state_nxt = ST_OL; end
      ST_OL:      begin cmd.op = OP_OL;      state_nxt = ST_OR; end
      ST_OR:      begin cmd.op = OP_OR;      state_nxt = ST_OUT; end
      ST_OUT: begin
        if (load_out) begin
          cmd.op    = OP_OUT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hdl/sldc_dp.sv =====
// Datapath: shared multiplier, level detector, gain computer and output beat register.
module sldc_dp #(
  parameter int SAMPLE_BITS = sldc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sldc_pkg::cmd_t                cmd,
  input  sldc_pkg::cfg_t                cfg,
  input  logic signed [SAMPLE_BITS-1:0] in_left_sample,
  input  logic signed [SAMPLE_BITS-1:0] in_right_sample,
  output logic signed [SAMPLE_BITS-1:0] out_left_out,
  output logic signed [SAMPLE_BITS-1:0] out_right_out
);
  import sldc_pkg::*;

  localparam int SB   = SAMPLE_BITS;
  localparam int SH_R = (SB > NORM_BITS) ? SB - NORM_BITS : 0;
  localparam int SH_L = (SB < NORM_BITS) ? NORM_BITS - SB : 0;
  localparam logic signed [SB-1:0]     OUT_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0]     OUT_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic signed [PROD_W-1:0] RND8  = PROD_W'(128);
  localparam logic signed [PROD_W-1:0] RND14 = PROD_W'(8192);
  localparam logic signed [PROD_W-1:0] RND16 = PROD_W'(32768);
  localparam logic signed [PROD_W-1:0] RND22 = PROD_W'(2097152);

  function automatic logic signed [SB-1:0] sat_round(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] y;
    y = (p + RND16) >>> 16;
    if (y > PROD_W'(OUT_MAX)) begin
      return OUT_MAX;
    end else if (y < PROD_W'(OUT_MIN)) begin
      return OUT_MIN;
    end
    return SB'(y);
  endfunction

  logic signed [SB-1:0]     xl_r, xr_r, xl_nxt, xr_nxt;
  logic [MAG_W-1:0]         mag_r, mag_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic [48:0]              s2_r, s2_nxt;
  logic [ACC_W-1:0]         acc_r, acc_nxt;
  logic [48:0]              msn_r, msn_nxt;
  logic [47:0]              ms_r, ms_nxt;
  logic                     zero_r, zero_nxt;
  logic [47:0]              norm_r, norm_nxt;
  logic [5:0]               sc_r, sc_nxt;
  logic [15:0]              frac_r, frac_nxt;
  logic signed [15:0]       level_r, level_nxt;
  logic                     gt_r, gt_nxt;
  logic signed [17:0]       target_r, target_nxt;
  logic [16:0]              a_r, a_nxt;
  logic signed [41:0]       envacc_r, envacc_nxt;
  logic signed [23:0]       env_r, env_nxt;
  logic signed [14:0]       n_r, n_nxt;
  logic [15:0]              f_r, f_nxt;
  logic [24:0]              g_r, g_nxt;
  logic [28:0]              tot_r, tot_nxt;
  logic signed [SB-1:0]     outl_r, outl_nxt;
  logic signed [SB-1:0]     ol_r, ol_nxt, or_r, or_nxt;

  logic signed [SB:0]       sum_in;
  logic [SB:0]              abs_in;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic                     mul_en;
  logic [ACC_W-1:0]         acc_sum;
  logic [50:0]              ms_full;
  logic [47:0]              ms_sat;
  logic [31:0]              mq;
  logic [30:0]              mn;
  logic signed [6:0]        kexp;
  logic signed [22:0]       log2_v;
  logic signed [PROD_W-1:0] rnd;
  logic signed [18:0]       lv;
  logic signed [16:0]       diff;
  logic signed [15:0]       irm;
  logic signed [17:0]       tg;
  logic [16:0]              one_minus_a;
  logic signed [42:0]       env_sum;
  logic [16:0]              p_v;
  logic [14:0]              nneg;

  assign out_left_out  = ol_r;
  assign out_right_out = or_r;

  always_comb begin
    sum_in = (SB+1)'(in_left_sample) + (SB+1)'(in_right_sample);
    abs_in = sum_in[SB] ? (SB+1)'(-sum_in) : (SB+1)'(sum_in);
  end

  always_comb begin
    xl_nxt = xl_r;   xr_nxt = xr_r;   mag_nxt = mag_r;   s2_nxt = s2_r;
    acc_nxt = acc_r; msn_nxt = msn_r; ms_nxt = ms_r;     zero_nxt = zero_r;
    norm_nxt = norm_r; sc_nxt = sc_r; frac_nxt = frac_r; level_nxt = level_r;
    gt_nxt = gt_r;   target_nxt = target_r; a_nxt = a_r; envacc_nxt = envacc_r;
    env_nxt = env_r; n_nxt = n_r;     f_nxt = f_r;       g_nxt = g_r;
    tot_nxt = tot_r; outl_nxt = outl_r; ol_nxt = ol_r;   or_nxt = or_r;
    mul_en = 1'b0;   mul_a = '0;      mul_b = '0;
    acc_sum = '0;    ms_full = '0;    ms_sat = '0;
    mq = '0;         mn = '0;         kexp = '0;         log2_v = '0;
    rnd = '0;        lv = '0;         diff = '0;         irm = '0;
    tg = '0;         one_minus_a = '0; env_sum = '0;     p_v = '0;
    nneg = '0;
    unique case (cmd.op)
      OP_NONE: ;
      OP_LOAD: begin
        xl_nxt  = in_left_sample;
        xr_nxt  = in_right_sample;
        mag_nxt = MAG_W'(abs_in >> SH_R) << SH_L;
      end
      OP_SQ: begin
        mul_en = 1'b1;
        mul_a  = signed'(MUL_W'(mag_r));
        mul_b  = signed'(MUL_W'(mag_r));
      end
      OP_MS_HI: begin
        s2_nxt = prod_r[48:0];
        mul_en = 1'b1;
        mul_a  = signed'(MUL_W'(ms_r[47:24]));
        mul_b  = signed'(MUL_W'(cfg.alpha));
      end
      OP_MS_LO: begin
        acc_nxt = ACC_W'(prod_r[41:0]) << 24;
        mul_en  = 1'b1;
        mul_a   = signed'(MUL_W'(ms_r[23:0]));
        mul_b   = signed'(MUL_W'(cfg.alpha));
      end
      OP_S2_HI: begin
        acc_sum = acc_r + ACC_W'(prod_r[41:0]);
        msn_nxt = acc_sum[64:16];
        mul_en  = 1'b1;
        mul_a   = signed'(MUL_W'(s2_r[48:24]));
        mul_b   = signed'(MUL_W'(cfg.w));
      end
      OP_S2_LO: begin
        acc_nxt = ACC_W'(prod_r[41:0]) << 24;
        mul_en  = 1'b1;
        mul_a   = signed'(MUL_W'(s2_r[23:0]));
        mul_b   = signed'(MUL_W'(cfg.w));
      end
      OP_MS_SUM: begin
        acc_sum  = acc_r + ACC_W'(prod_r[41:0]);
        ms_full  = 51'(msn_r) + 51'(acc_sum[65:16]);
        ms_sat   = (|ms_full[50:48]) ? '1 : ms_full[47:0];
        ms_nxt   = ms_sat;
        norm_nxt = ms_sat;
        zero_nxt = (ms_sat == '0);
        sc_nxt   = '0;
      end
      OP_NORM: begin
        unique case (cmd.cnt[2:0])
          3'd0: if (norm_r[47:16] == '0) begin
            norm_nxt = norm_r << 32; sc_nxt = sc_r + 6'd32;
          end
          3'd1: if (norm_r[47:32] == '0) begin
            norm_nxt = norm_r << 16; sc_nxt = sc_r + 6'd16;
          end
          3'd2: if (norm_r[47:40] == '0) begin
            norm_nxt = norm_r << 8;  sc_nxt = sc_r + 6'd8;
          end
          3'd3: if (norm_r[47:44] == '0) begin
            norm_nxt = norm_r << 4;  sc_nxt = sc_r + 6'd4;
          end
          3'd4: if (norm_r[47:46] == '0) begin
            norm_nxt = norm_r << 2;  sc_nxt = sc_r + 6'd2;
          end
          3'd5: if (!norm_r[47]) begin
            norm_nxt = norm_r << 1;  sc_nxt = sc_r + 6'd1;
          end
          default: ;
        endcase
      end
      OP_MANT: begin
        frac_nxt = '0;
        mul_en   = 1'b1;
        mul_a    = signed'(MUL_W'(norm_r[47:17]));
        mul_b    = signed'(MUL_W'(norm_r[47:17]));
      end
      OP_LOG: begin
        // one fraction bit per squaring
        mq = prod_r[61:30];
        if (mq[31]) begin
          frac_nxt[cmd.cnt] = 1'b1;
          mn = mq[31:1];
        end else begin
          mn = mq[30:0];
        end
        mul_en = 1'b1;
        mul_a  = signed'(MUL_W'(mn));
        mul_b  = signed'(MUL_W'(mn));
      end
      OP_LVL_MUL: begin
        kexp   = 7'sd1 - signed'({1'b0, sc_r});
        log2_v = {kexp, frac_r};
        mul_en = 1'b1;
        mul_a  = MUL_W'(log2_v);
        mul_b  = signed'(MUL_W'(DB_PER_LOG2));
      end
      OP_LVL: begin
        rnd = prod_r + RND22;
        lv  = rnd[40:22];
        if (zero_r || lv < -19'sd32768) begin
          level_nxt = LEVEL_FLOOR;
        end else begin
          level_nxt = 16'(lv);
        end
      end
      OP_TGT_MUL: begin
        diff   = 17'(level_r) - 17'(cfg.thr);
        gt_nxt = (level_r > cfg.thr);
        irm    = signed'({1'b0, cfg.ir}) - signed'({1'b0, ONE_Q14});
        mul_en = 1'b1;
        mul_a  = MUL_W'(diff);
        mul_b  = MUL_W'(irm);
      end
      OP_TGT: begin
        rnd        = prod_r + RND14;
        tg         = gt_r ? rnd[31:14] : '0;
        target_nxt = tg;
        a_nxt      = (24'(tg) < env_r) ? cfg.att : cfg.rel;
      end
      OP_ENV_A: begin
        one_minus_a = ONE_Q16 - a_r;
        mul_en      = 1'b1;
        mul_a       = MUL_W'(env_r);
        mul_b       = signed'(MUL_W'(one_minus_a));
      end
      OP_ENV_B: begin
        envacc_nxt = $signed(prod_r[41:0]);
        mul_en     = 1'b1;
        mul_a      = MUL_W'(target_r);
        mul_b      = signed'(MUL_W'(a_r));
      end
      OP_ENV_C: begin
        env_sum = 43'(envacc_r) + 43'($signed(prod_r[41:0])) + 43'sd32768;
        env_nxt = env_sum[39:16];
      end
      OP_E_MUL: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(env_r);
        mul_b  = signed'(MUL_W'(LOG2_PER_DB));
      end
      OP_E: begin
        rnd    = prod_r + RND8;
        n_nxt  = rnd[38:24];
        f_nxt  = rnd[23:8];
        mul_en = 1'b1;
        mul_a  = signed'(MUL_W'(POLY_C3));
        mul_b  = signed'(MUL_W'(rnd[23:8]));
      end
      OP_H1: begin
        p_v    = 17'(POLY_C2) + 17'(prod_r[28:16]);
        mul_en = 1'b1;
        mul_a  = signed'(MUL_W'(p_v));
        mul_b  = signed'(MUL_W'(f_r));
      end
      OP_H2: begin
        p_v    = 17'(POLY_C1) + 17'(prod_r[30:16]);
        mul_en = 1'b1;
        mul_a  = signed'(MUL_W'(p_v));
        mul_b  = signed'(MUL_W'(f_r));
      end
      OP_H3: begin
        p_v  = ONE_Q16 + 17'(prod_r[31:16]);
        nneg = 15'(-n_r);
        if (!n_r[14]) begin
          g_nxt = 25'(p_v) << ((n_r > 15'sd8) ? 4'd8 : n_r[3:0]);
        end else if (nneg > 15'd40) begin
          g_nxt = '0;
        end else begin
          g_nxt = 25'(p_v) >> nneg;
        end
      end
      OP_MK: begin
        mul_en = 1'b1;
        mul_a  = signed'(MUL_W'(cfg.mk));
        mul_b  = signed'(MUL_W'(g_r));
      end
      OP_OL: begin
        tot_nxt = prod_r[40:12];
        mul_en  = 1'b1;
        mul_a   = MUL_W'(xl_r);
        mul_b   = signed'(MUL_W'(prod_r[40:12]));
      end
      OP_OR: begin
        outl_nxt = sat_round(prod_r);
        mul_en   = 1'b1;
        mul_a    = MUL_W'(xr_r);
        mul_b    = signed'(MUL_W'(tot_r));
      end
      OP_OUT: begin
        ol_nxt = outl_r;
        or_nxt = sat_round(prod_r);
      end
      default: ;
    endcase
    prod_nxt = mul_en ? mul_a * mul_b : prod_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_r  <= '0;
      env_r <= ENV_RESET;
    end else begin
      ms_r  <= ms_nxt;
      env_r <= env_nxt;
    end
  end

  always_ff @(posedge clk) begin
    xl_r     <= xl_nxt;
    xr_r     <= xr_nxt;
    mag_r    <= mag_nxt;
    prod_r   <= prod_nxt;
    s2_r     <= s2_nxt;
    acc_r    <= acc_nxt;
    msn_r    <= msn_nxt;
    zero_r   <= zero_nxt;
    norm_r   <= norm_nxt;
    sc_r     <= sc_nxt;
    frac_r   <= frac_nxt;
    level_r  <= level_nxt;
    gt_r     <= gt_nxt;
    target_r <= target_nxt;
    a_r      <= a_nxt;
    envacc_r <= envacc_nxt;
    n_r      <= n_nxt;
    f_r      <= f_nxt;
    g_r      <= g_nxt;
    tot_r    <= tot_nxt;
    outl_r   <= outl_nxt;
    ol_r     <= ol_nxt;
    or_r     <= or_nxt;
  end

endmodule
